/* src/sha256_pkg.sv */
// Shared types, round constants and initial hash values for the SHA-256 digest unit.
// No dependencies; every other file in src imports this package.
package sha256_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef logic [15:0][31:0] block_t;
    typedef logic [7:0][31:0]  hash_t;

    // One classified input word as it travels through the queue
    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       is_end;
    } msg_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_LEN,
        ST_EMIT
    } back_state_t;

    function automatic logic [31:0] init_hash(input logic [2:0] idx);
        logic [31:0] v;
        unique case (idx)
            3'd0: v = 32'h6a09e667;
            3'd1: v = 32'hbb67ae85;
            3'd2: v = 32'h3c6ef372;
            3'd3: v = 32'ha54ff53a;
            3'd4: v = 32'h510e527f;
            3'd5: v = 32'h9b05688c;
            3'd6: v = 32'h1f83d9ab;
            3'd7: v = 32'h5be0cd19;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] k;
        unique case (r)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage

/* src/sha256_front.sv */
// Input side of the SHA-256 digest unit: accepts stream words, drops idle ones,
// and hands byte / end-of-message operations to the queue. Uses sha256_pkg.
module sha256_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,
    input  logic                s_axis_tuser,
    input  logic                s_axis_tlast,
    output logic                push,
    output sha256_pkg::msg_op_t push_op,
    input  logic                full
);
    import sha256_pkg::*;

    logic    hold_valid_reg;
    msg_op_t hold_op_reg;
    logic    accept;
    logic    keep;

    assign push          = hold_valid_reg && !full;
    assign push_op       = hold_op_reg;
    assign s_axis_tready = !hold_valid_reg || !full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    // a word with neither a byte nor an end mark changes nothing: drop it
    assign keep          = s_axis_tuser || s_axis_tlast;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (accept && keep)
        begin
            hold_valid_reg <= 1'b1;
        end
        else if (push)
        begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && keep)
        begin
            hold_op_reg.data     <= s_axis_tdata;
            hold_op_reg.has_byte <= s_axis_tuser;
            hold_op_reg.is_end   <= s_axis_tlast;
        end
    end

endmodule

/* src/sha256_queue.sv */
// Short queue of classified operations between the front and back of the digest unit.
// Uses sha256_pkg for the operation type.
module sha256_queue #(
    parameter int DEPTH = sha256_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sha256_pkg::msg_op_t push_op,
    output logic                full,
    input  logic                pop,
    output sha256_pkg::msg_op_t pop_op,
    output logic                empty
);
    import sha256_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    msg_op_t       mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full   = (count_reg == CW'(DEPTH));
    assign empty  = (count_reg == '0);
    assign pop_op = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

/* src/sha256_compress.sv */
// SHA-256 compression engine: one round per cycle over a sliding 16-word schedule.
// Uses sha256_pkg for block/hash types and the round constant table.
module sha256_compress (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  sha256_pkg::block_t block,
    input  sha256_pkg::hash_t  hash_in,
    output logic               done,
    output sha256_pkg::hash_t  vars
);
    import sha256_pkg::*;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    hash_t       v_reg;
    block_t      w_reg;
    logic [5:0]  round_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [31:0] s0_w, s1_w, w_new;
    logic [31:0] s1_e, ch_e, s0_a, maj_a, t1, t2;

    always_comb
    begin
        s0_w  = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1_w  = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = s1_w + w_reg[9] + s0_w + w_reg[0];
        s1_e  = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        ch_e  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        s0_a  = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        maj_a = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1    = v_reg[7] + s1_e + ch_e + round_k(round_reg) + w_reg[0];
        t2    = s0_a + maj_a;
    end

    assign done = done_reg;
    assign vars = v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            round_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !start && (round_reg == 6'd63);
            if (start)
            begin
                busy_reg  <= 1'b1;
                round_reg <= '0;
            end
            else if (busy_reg)
            begin
                round_reg <= round_reg + 6'd1;
                if (round_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg <= hash_in;
            w_reg <= block;
        end
        else if (busy_reg)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
            // slide the schedule: word 0 is always the current round's input
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= w_new;
        end
    end

endmodule

/* src/sha256_back.sv */
// Back end of the SHA-256 digest unit: packs bytes, pads, sequences compressions
// and emits the digest through an output register. Uses sha256_pkg.
module sha256_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                empty,
    output logic                pop,
    input  sha256_pkg::msg_op_t pop_op,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [31:0]         m_axis_tdata,
    output logic [2:0]          m_axis_tuser,
    output logic                m_axis_tlast,
    output logic                cmp_start,
    output sha256_pkg::block_t  cmp_block,
    output sha256_pkg::hash_t   cmp_hash,
    input  logic                cmp_done,
    input  sha256_pkg::hash_t   cmp_vars
);
    import sha256_pkg::*;

    back_state_t state_reg, state_next;
    back_state_t ret_reg, ret_next;
    block_t      block_reg;
    block_t      block_next;
    block_t      padded;
    hash_t       hash_reg;
    logic [60:0] count_reg;
    logic        extra_reg;
    logic [2:0]  idx_reg;
    logic        m_valid_reg;
    logic [31:0] m_data_reg;
    logic [2:0]  m_user_reg;
    logic        m_last_reg;

    logic [5:0]  pos;
    logic        take_byte;
    logic        out_load;
    logic [63:0] bit_len;

    assign pos     = count_reg[5:0];
    assign bit_len = {count_reg, 3'b000};

    // next state
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    if (pop_op.has_byte && pos == 6'd63)
                    begin
                        state_next = ST_COMP;
                        ret_next   = pop_op.is_end ? ST_PAD : ST_IDLE;
                    end
                    else if (pop_op.is_end)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                if (pos[5:3] == 3'b111)
                begin
                    state_next = ST_COMP;
                    ret_next   = ST_LEN;
                end
                else
                begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN:
            begin
                state_next = ST_COMP;
                ret_next   = ST_EMIT;
            end
            ST_COMP:
            begin
                if (cmp_done)
                begin
                    state_next = ret_reg;
                end
            end
            ST_EMIT:
            begin
                if (out_load && idx_reg == 3'd7)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        pop       = (state_reg == ST_IDLE) && !empty;
        take_byte = pop && pop_op.has_byte;
        out_load  = (state_reg == ST_EMIT) && (!m_valid_reg || m_axis_tready);
        cmp_start = (take_byte && pos == 6'd63)
                    || (state_reg == ST_PAD && pos[5:3] == 3'b111)
                    || (state_reg == ST_LEN);
    end

    // padding: 0x80 at the next free byte, zeros after it
    always_comb
    begin
        padded = block_reg;
        for (int j = 0; j < 16; j++)
        begin
            for (int b = 0; b < 4; b++)
            begin
                if (6'(4 * j + b) == pos)
                begin
                    padded[j][8*(3-b) +: 8] = PAD_BYTE;
                end
                else if (6'(4 * j + b) > pos)
                begin
                    padded[j][8*(3-b) +: 8] = 8'h00;
                end
            end
        end
    end

    // block contents after this cycle; a compression starting now loads this value
    always_comb
    begin
        block_next = block_reg;
        if (take_byte)
        begin
            block_next[pos[5:2]][{~pos[1:0], 3'b000} +: 8] = pop_op.data;
        end
        if (state_reg == ST_PAD)
        begin
            block_next = padded;
        end
        if (state_reg == ST_LEN)
        begin
            if (extra_reg)
            begin
                for (int j = 0; j < 14; j++)
                begin
                    block_next[j] = 32'h0;
                end
            end
            block_next[14] = bit_len[63:32];
            block_next[15] = bit_len[31:0];
        end
    end

    assign cmp_block     = block_next;
    assign cmp_hash      = hash_reg;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;
    assign m_axis_tlast  = m_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            ret_reg     <= ST_IDLE;
            count_reg   <= '0;
            extra_reg   <= 1'b0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= init_hash(3'(i));
            end
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            if (take_byte)
            begin
                count_reg <= count_reg + 61'd1;
            end
            if (state_reg == ST_PAD)
            begin
                extra_reg <= (pos[5:3] == 3'b111);
            end
            if (state_reg == ST_COMP && cmp_done)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hash_reg[i] <= hash_reg[i] + cmp_vars[i];
                end
            end
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
                idx_reg     <= idx_reg + 3'd1;
                if (idx_reg == 3'd7)
                begin
                    // digest handed off: start the next message afresh
                    count_reg <= '0;
                    for (int i = 0; i < 8; i++)
                    begin
                        hash_reg[i] <= init_hash(3'(i));
                    end
                end
            end
            else if (m_valid_reg && m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        block_reg <= block_next;
        if (out_load)
        begin
            m_data_reg <= hash_reg[idx_reg];
            m_user_reg <= idx_reg;
            m_last_reg <= (idx_reg == 3'd7);
        end
    end

endmodule

/* src/sha256_message_digest_unit.sv */
// Top level of the SHA-256 message digest unit: front end, operation queue,
// back end and compression engine. Depends on sha256_pkg and the sha256_* modules.
//
// Usage:
//   Input stream (s_axis_*): one word per message byte. tdata[7:0] is the byte,
//   tuser flags that tdata carries a byte, tlast marks the end of the message
//   (it may come with or without a byte). Words with neither flag are dropped.
//   Output stream (m_axis_*): eight 32-bit digest words per message, first word
//   of the digest first; tuser gives the word position 0..7, tlast marks word 7.
// Throughput: the back end takes bytes while idle; every 64th byte also starts a
//   compression (one round per cycle in the compression engine), and the back
//   end takes no further byte until that compression is done.
// Sequence: after the end word reaches the back end, the padding state runs,
//   an extra compression follows when 56 or more bytes are pending, then the
//   length state and the final compression; the digest words then follow one
//   per cycle while the receiver takes them.
// Stalls: the output register holds a word until it is taken; the queue keeps
//   accepting input while the back end compresses or waits on the receiver, until it is full.
// Reset: clears the queue, the byte count and the output valid flag and loads
//   the initial hash values; the block is ready for a new message at once.
module sha256_message_digest_unit #(
    parameter int QUEUE_DEPTH = sha256_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] msg_byte
    input  logic        s_axis_tuser,   // [0] byte_valid
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_index
    output logic        m_axis_tlast
);
    import sha256_pkg::*;

    logic    q_push;
    msg_op_t q_push_op;
    logic    q_full;
    logic    q_pop;
    msg_op_t q_pop_op;
    logic    q_empty;
    logic    cmp_start;
    block_t  cmp_block;
    hash_t   cmp_hash;
    logic    cmp_done;
    hash_t   cmp_vars;

    sha256_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .push          (q_push),
        .push_op       (q_push_op),
        .full          (q_full)
    );

    sha256_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (q_push_op),
        .full    (q_full),
        .pop     (q_pop),
        .pop_op  (q_pop_op),
        .empty   (q_empty)
    );

    sha256_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .empty         (q_empty),
        .pop           (q_pop),
        .pop_op        (q_pop_op),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cmp_start     (cmp_start),
        .cmp_block     (cmp_block),
        .cmp_hash      (cmp_hash),
        .cmp_done      (cmp_done),
        .cmp_vars      (cmp_vars)
    );

    sha256_compress u_compress (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmp_start),
        .block   (cmp_block),
        .hash_in (cmp_hash),
        .done    (cmp_done),
        .vars    (cmp_vars)
    );

    // the queue is never written while full nor read while empty
    assert property (@(posedge clk) disable iff (!rst_n) !(q_push && q_full))
        else $error("queue write while full");
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
        else $error("queue read while empty");

    // the last digest word always carries position seven
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == 3'd7))
        else $error("last digest word at wrong position");

    // a new compression never starts while the previous one is finishing
    assert property (@(posedge clk) disable iff (!rst_n) cmp_start |=> !cmp_done)
        else $error("compression done too early after start");

endmodule
